/* sv/bcs_pkg.sv */
package bcs_pkg;

    // width of the returned coefficients
    localparam int COEF_WIDTH = 64;

    // division steps allowed before giving up
    localparam int MAX_STEPS  = 64;
    localparam int STEP_WIDTH = $clog2(MAX_STEPS + 1);

    typedef logic [2:0] t_state;

    localparam t_state S_IDLE  = 3'd0;
    localparam t_state S_CHECK = 3'd1;
    localparam t_state S_DIV   = 3'd2;
    localparam t_state S_UPD   = 3'd3;
    localparam t_state S_MUL   = 3'd4;
    localparam t_state S_DONE  = 3'd5;

endpackage

/* sv/bezout_coefficient_solver.sv */
// bezout coefficient solver: extended euclidean algorithm on one shared datapath
// input channel (i_in_valid / o_in_ready) carries first operand, second operand
// and target; output channel (o_out_valid / i_out_ready) carries signed 64-bit
// coefficients p and q with p * first + q * second == target, plus a
// no-solution flag that is set (with zero coefficients) when the operands
// are not coprime
// one transaction is worked on at a time: o_in_ready is high only while the
// sequencer is idle, so the next transaction is taken only after the previous
// result has been posted; each euclid division step is one restoring-division
// pass through the shared subtractor plus an update and a check state, and the
// number of steps is at most about 45 for 31-bit operands and capped at
// MAX_STEPS; the final scaling by the target is a bit-serial multiply; a
// failing pair ends at the first zero remainder or at the step cap
// the result sits in an output register; if the receiver stalls, the next
// result waits in the sequencer until the register is free
// synchronous active-low reset returns the sequencer to idle and drops
// o_out_valid; no result is lost or repeated across a stall
module bezout_coefficient_solver
    import bcs_pkg::*;
#(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [OPERAND_WIDTH-1:0]     i_first_operand,
    input  logic [OPERAND_WIDTH-1:0]     i_second_operand,
    input  logic [OPERAND_WIDTH-1:0]     i_target,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COEF_WIDTH-1:0] o_coef_first,
    output logic signed [COEF_WIDTH-1:0] o_coef_second,
    output logic                         o_no_solution
);

    // coefficient magnitudes stay at or below the larger operand, so two
    // extra bits (carry and sign) cover every intermediate value
    localparam int CW = OPERAND_WIDTH + 2;
    localparam int BW = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

    localparam logic [BW-1:0]         CNT_TOP = BW'(OPERAND_WIDTH - 1);
    localparam logic [OPERAND_WIDTH-1:0] ONE_OP = OPERAND_WIDTH'(1);
    localparam logic [STEP_WIDTH-1:0] STEP_MAX = STEP_WIDTH'(MAX_STEPS);

    t_state                    r_state;
    logic                      r_out_valid;

    // euclid pair, larger value first
    logic [OPERAND_WIDTH-1:0]  r_a;
    logic [OPERAND_WIDTH-1:0]  r_b;
    logic                      r_swap;
    logic                      r_fail;
    logic [STEP_WIDTH-1:0]     r_steps;
    logic [BW-1:0]             r_cnt;

    // divider state
    logic [OPERAND_WIDTH-1:0]  r_dvd;
    logic [OPERAND_WIDTH-1:0]  r_rem;

    // running coefficients: r_a = x0*A + y0*B, r_b = x1*A + y1*B
    logic signed [CW-1:0]      r_x0;
    logic signed [CW-1:0]      r_x1;
    logic signed [CW-1:0]      r_y0;
    logic signed [CW-1:0]      r_y1;
    // quotient times x1 and y1, built msb first alongside the division
    logic signed [CW-1:0]      r_ax;
    logic signed [CW-1:0]      r_ay;

    // final scaling by the target
    logic [OPERAND_WIDTH-1:0]  r_k;
    logic signed [COEF_WIDTH-1:0] r_px;
    logic signed [COEF_WIDTH-1:0] r_py;

    logic [COEF_WIDTH-1:0]     r_coef_first;
    logic [COEF_WIDTH-1:0]     r_coef_second;
    logic                      r_no_solution;

    // shared restoring-division step
    logic [OPERAND_WIDTH:0]    n_trial;
    logic                      n_qbit;
    logic [OPERAND_WIDTH:0]    n_diff;
    logic [OPERAND_WIDTH-1:0]  n_rem;
    logic signed [CW-1:0]      n_ax;
    logic signed [CW-1:0]      n_ay;

    // shared shift-add step of the target multiply
    logic signed [COEF_WIDTH-1:0] n_px;
    logic signed [COEF_WIDTH-1:0] n_py;
    logic signed [COEF_WIDTH-1:0] w_x0_ext;
    logic signed [COEF_WIDTH-1:0] w_y0_ext;

    logic                      w_out_free;

    assign n_trial = {r_rem, r_dvd[OPERAND_WIDTH-1]};
    assign n_qbit  = (n_trial >= {1'b0, r_b});
    assign n_diff  = n_qbit ? (n_trial - {1'b0, r_b}) : n_trial;
    // the remainder is below the divisor, so it fits the operand width
    assign n_rem   = n_diff[OPERAND_WIDTH-1:0];
    assign n_ax    = {r_ax[CW-2:0], 1'b0} + (n_qbit ? r_x1 : CW'(0));
    assign n_ay    = {r_ay[CW-2:0], 1'b0} + (n_qbit ? r_y1 : CW'(0));

    assign w_x0_ext = {{(COEF_WIDTH-CW){r_x0[CW-1]}}, r_x0};
    assign w_y0_ext = {{(COEF_WIDTH-CW){r_y0[CW-1]}}, r_y0};
    assign n_px = {r_px[COEF_WIDTH-2:0], 1'b0}
                + (r_k[OPERAND_WIDTH-1] ? w_x0_ext : COEF_WIDTH'(0));
    assign n_py = {r_py[COEF_WIDTH-2:0], 1'b0}
                + (r_k[OPERAND_WIDTH-1] ? w_y0_ext : COEF_WIDTH'(0));

    assign w_out_free = !r_out_valid || i_out_ready;

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result is posted as the old one leaves, so valid stays up
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_a == ONE_OP) begin
                        r_state <= S_MUL;
                    end else if (r_b == '0 || r_steps == STEP_MAX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= S_CHECK;
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // order the pair so the larger value leads
                if (i_first_operand < i_second_operand) begin
                    r_a    <= i_second_operand;
                    r_b    <= i_first_operand;
                    r_swap <= 1'b1;
                end else begin
                    r_a    <= i_first_operand;
                    r_b    <= i_second_operand;
                    r_swap <= 1'b0;
                end
                r_k     <= i_target;
                r_x0    <= CW'(1);
                r_x1    <= '0;
                r_y0    <= '0;
                r_y1    <= CW'(1);
                r_steps <= '0;
                r_fail  <= 1'b0;
            end
            S_CHECK: begin
                r_cnt <= CNT_TOP;
                r_rem <= '0;
                r_dvd <= r_a;
                r_ax  <= '0;
                r_ay  <= '0;
                r_px  <= '0;
                r_py  <= '0;
                if (r_a != ONE_OP && (r_b == '0 || r_steps == STEP_MAX)) begin
                    r_fail <= 1'b1;
                end
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[OPERAND_WIDTH-2:0], 1'b0};
                r_ax  <= n_ax;
                r_ay  <= n_ay;
                r_cnt <= r_cnt - BW'(1);
            end
            S_UPD: begin
                r_a     <= r_b;
                r_b     <= r_rem;
                r_x0    <= r_x1;
                r_x1    <= r_x0 - r_ax;
                r_y0    <= r_y1;
                r_y1    <= r_y0 - r_ay;
                r_steps <= r_steps + STEP_WIDTH'(1);
            end
            S_MUL: begin
                r_px  <= n_px;
                r_py  <= n_py;
                r_k   <= {r_k[OPERAND_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - BW'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    if (r_fail) begin
                        r_coef_first  <= '0;
                        r_coef_second <= '0;
                        r_no_solution <= 1'b1;
                    end else if (r_swap) begin
                        r_coef_first  <= r_py;
                        r_coef_second <= r_px;
                        r_no_solution <= 1'b0;
                    end else begin
                        r_coef_first  <= r_px;
                        r_coef_second <= r_py;
                        r_no_solution <= 1'b0;
                    end
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_coef_first  = r_coef_first;
    assign o_coef_second = r_coef_second;
    assign o_no_solution = r_no_solution;

endmodule
